// ----- rtl/pbr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbr_pkg
// Shared constants and command codes for the pixel histogram bar renderer.
// ----------------------------------------------------------------------------
package pbr_pkg;

	localparam int COUNT_BITS_DEF = 24;  // bin counter width
	localparam int BAR_LEVELS_DEF = 64;  // levels of the bar chart
	localparam int PIX_W          = 8;   // gray pixel and bin index width
	localparam int NUM_BINS       = 1 << PIX_W;
	localparam int LEVEL_W        = 6;   // width of the queried level
	localparam int CMD_W          = 1;
	localparam int BAR_W          = 8;

	localparam logic [BAR_W-1:0] BAR_ON  = 8'hFF;
	localparam logic [BAR_W-1:0] BAR_OFF = 8'h00;

	// command carried in the input tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

endpackage
`default_nettype wire

// ----- rtl/pixel_histogram_bar_render.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted item passes from the stage 1 registers into the output register
// once that register is free or drained. Throughput: one item per cycle while the
// result channel is not stalled; the bin store read-modify-write is split over the
// registered read and the compute stage, with a write-to-read bypass.
// Reset: asynchronous, clears the pipeline, the peak and a per-bin valid bit;
// a bin whose valid bit is clear reads as zero, so the store is empty at once.
// ----------------------------------------------------------------------------
// pixel_histogram_bar_render
// 256-bin gray-level histogram with saturating counts, a running peak and a
// bar-chart query that compares count*BAR_LEVELS against level*peak.
// ----------------------------------------------------------------------------
module pixel_histogram_bar_render #(
	parameter int COUNT_BITS = pbr_pkg::COUNT_BITS_DEF,
	parameter int BAR_LEVELS = pbr_pkg::BAR_LEVELS_DEF,
	parameter int OUT_W      = ((2 * COUNT_BITS + pbr_pkg::BAR_W + 7) / 8) * 8
) (
	input  wire              clk,
	input  wire              arst_n,
	// input item
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire  [23:0]      s_tdata,   // pixel_value[7:0], bin_index[15:8], level[21:16]
	input  wire  [0:0]       s_tuser,   // cmd[0]
	// result item
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [OUT_W-1:0] m_tdata    // bin_count, peak, bar_pixel (from bit 0 up)
);
	import pbr_pkg::*;

	localparam int PROD_W = COUNT_BITS + 9;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// input fields
	logic [PIX_W-1:0]   in_pixel;
	logic [PIX_W-1:0]   in_bin;
	logic [LEVEL_W-1:0] in_level;
	cmd_t               in_cmd;
	logic [PIX_W-1:0]   in_addr;
	logic               s_accept;
	logic               advance;

	// stage 1 registers
	logic               s1_valid_q;
	cmd_t               cmd_s1;
	logic [PIX_W-1:0]   addr_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [COUNT_BITS-1:0] mem_rd_s1;
	logic               hit_s1;
	logic               fwd_s1;
	logic [COUNT_BITS-1:0] fwd_data_s1;

	// store and state
	logic [COUNT_BITS-1:0] bin_mem [NUM_BINS];
	logic [NUM_BINS-1:0]   bin_valid_q;
	logic [COUNT_BITS-1:0] peak_q;

	// compute
	logic [COUNT_BITS-1:0] count_old;
	logic [COUNT_BITS-1:0] count_new;
	logic [COUNT_BITS-1:0] peak_new;
	logic [PROD_W-1:0]     lhs;
	logic [PROD_W-1:0]     rhs;
	logic                  reaches;
	logic                  wr_en;

	// output register
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic [COUNT_BITS-1:0] out_peak_q;
	logic [BAR_W-1:0]      out_bar_q;

	// unpack the input item
	assign in_pixel = s_tdata[PIX_W-1:0];
	assign in_bin   = s_tdata[2*PIX_W-1:PIX_W];
	assign in_level = s_tdata[2*PIX_W+LEVEL_W-1:2*PIX_W];
	assign in_cmd   = cmd_t'(s_tuser[0]);
	assign in_addr  = (in_cmd == CMD_ADD) ? in_pixel : in_bin;

	// advance when the output register is free or being drained
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !s1_valid_q || advance;
	assign s_accept = s_tvalid && s_tready;
	assign wr_en    = s1_valid_q && advance && (cmd_s1 == CMD_ADD);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload, valid-bit lookup and bypass of the write in flight
	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1      <= in_cmd;
			addr_s1     <= in_addr;
			level_s1    <= in_level;
			hit_s1      <= bin_valid_q[in_addr];
			fwd_s1      <= wr_en && (addr_s1 == in_addr);
			fwd_data_s1 <= count_new;
		end
	end

	// bin store: registered read, write from the compute stage
	always_ff @(posedge clk) begin
		if (s_accept) begin
			mem_rd_s1 <= bin_mem[in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bin_mem[addr_s1] <= count_new;
		end
	end

	// valid bits and peak
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_q <= '0;
			peak_q      <= '0;
		end else if (wr_en) begin
			bin_valid_q[addr_s1] <= 1'b1;
			peak_q               <= peak_new;
		end
	end

	// bin update and bar comparison
	always_comb begin
		if (fwd_s1) begin
			count_old = fwd_data_s1;
		end else if (hit_s1) begin
			count_old = mem_rd_s1;
		end else begin
			count_old = '0;
		end
		count_new = (count_old == COUNT_MAX) ? count_old : count_old + COUNT_BITS'(1);
		peak_new  = (count_new > peak_q) ? count_new : peak_q;
		lhs       = PROD_W'(count_old) * PROD_W'(BAR_LEVELS);
		rhs       = PROD_W'(level_s1) * PROD_W'(peak_q);
		if (peak_q == '0) begin
			reaches = (level_s1 == '0);
		end else begin
			reaches = (lhs >= rhs);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid_q) begin
			if (cmd_s1 == CMD_ADD) begin
				out_count_q <= count_new;
				out_peak_q  <= peak_new;
				out_bar_q   <= BAR_OFF;
			end else begin
				out_count_q <= count_old;
				out_peak_q  <= peak_q;
				out_bar_q   <= reaches ? BAR_ON : BAR_OFF;
			end
		end
	end

	// pack the result item, zero-filled up to whole bytes
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_bar_q, out_peak_q, out_count_q});

endmodule
`default_nettype wire

// ----- bench/histogram_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_checker
// Watches both item channels of the histogram bar renderer. It keeps its own
// bin tallies and running peak, predicts each result and compares the result
// items, in order, field by field.
// ----------------------------------------------------------------------------
module histogram_checker #(
	parameter int COUNT_BITS = pbr_pkg::COUNT_BITS_DEF,
	parameter int BAR_LEVELS = pbr_pkg::BAR_LEVELS_DEF,
	parameter int OUT_W      = ((2 * COUNT_BITS + pbr_pkg::BAR_W + 7) / 8) * 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	input  wire                   s_tready,
	input  wire  [23:0]           s_tdata,   // pixel_value[7:0], bin_index[15:8], level[21:16]
	input  wire  [0:0]            s_tuser,   // cmd[0]
	input  wire                   m_tvalid,
	input  wire                   m_tready,
	input  wire  [OUT_W-1:0]      m_tdata,   // bin_count, peak, bar_pixel (from bit 0 up)
	output int                    fails,
	output int                    checked,
	output int                    pending,
	output logic [COUNT_BITS-1:0] peak_now
);
	import pbr_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_FULL = '1;

	// result fields, bin_count in the lowest bits
	typedef struct packed {
		logic [BAR_W-1:0]      bar;
		logic [COUNT_BITS-1:0] peak;
		logic [COUNT_BITS-1:0] count;
	} bar_result_t;

	logic [COUNT_BITS-1:0] bin_tally [NUM_BINS];
	logic [COUNT_BITS-1:0] tallest;
	bar_result_t           expected_q [$];
	int                    n_fail;
	int                    n_checked;

	// bar height floor(count*levels/peak) >= level, done in integers; empty peak is height 0
	function automatic bit bar_reaches(logic [COUNT_BITS-1:0] cnt, logic [COUNT_BITS-1:0] pk,
			logic [LEVEL_W-1:0] lvl);
		longint unsigned lhs;
		longint unsigned rhs;
		if (pk == '0)
			return lvl == '0;
		lhs = cnt;
		lhs = lhs * BAR_LEVELS;
		rhs = lvl;
		rhs = rhs * pk;
		return lhs >= rhs;
	endfunction

	// advance the tallies by one item and return the result it should give
	function automatic bar_result_t tally_item(cmd_t op, logic [PIX_W-1:0] pix,
			logic [PIX_W-1:0] bin, logic [LEVEL_W-1:0] lvl);
		bar_result_t           r;
		logic [COUNT_BITS-1:0] cnt;
		r.bar = BAR_OFF;
		if (op == CMD_ADD) begin
			cnt = bin_tally[pix];
			if (cnt != COUNT_FULL)
				cnt = cnt + 1'b1;
			bin_tally[pix] = cnt;
			if (cnt > tallest)
				tallest = cnt;
		end else begin
			cnt = bin_tally[bin];
			if (bar_reaches(cnt, tallest, lvl))
				r.bar = BAR_ON;
		end
		r.count = cnt;
		r.peak  = tallest;
		return r;
	endfunction

	// predict on input items, compare on result items
	always @(posedge clk or negedge arst_n) begin : watch
		bar_result_t got;
		bar_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++)
				bin_tally[i] = '0;
			tallest = '0;
			expected_q.delete();
			n_fail    = 0;
			n_checked = 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_q.push_back(tally_item(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[15:8],
					s_tdata[21:16]));
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_q.size() == 0) begin
					$error("result item with nothing expected: %h", m_tdata);
					n_fail++;
				end else begin
					want = expected_q.pop_front();
					n_checked++;
					if (got.count !== want.count) begin
						$error("bin_count: expected %0d, got %0d", want.count, got.count);
						n_fail++;
					end
					if (got.peak !== want.peak) begin
						$error("peak: expected %0d, got %0d", want.peak, got.peak);
						n_fail++;
					end
					if (got.bar !== want.bar) begin
						$error("bar_pixel: expected %0d, got %0d", want.bar, got.bar);
						n_fail++;
					end
				end
			end
		end
		fails    <= n_fail;
		checked  <= n_checked;
		pending  <= expected_q.size();
		peak_now <= tallest;
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel adds and bar queries into the histogram bar renderer: a
// directed opening on the empty store, repeated bins and bar boundaries,
// then random items focused on a few busy bins, under random idling and
// stalls on both channels. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module testbench;
	import pbr_pkg::*;

	localparam int COUNT_BITS = COUNT_BITS_DEF;
	localparam int OUT_W      = ((2 * COUNT_BITS + BAR_W + 7) / 8) * 8;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [23:0]           s_tdata;
	logic [0:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;
	int                    fails;
	int                    checked;
	int                    pending;
	logic [COUNT_BITS-1:0] peak_now;

	int                    gap_pct = 0;
	int                    stall_pct = 0;
	int                    n_add = 0;
	int                    n_query = 0;
	logic [PIX_W-1:0]      busy_bins [8];

	pixel_histogram_bar_render dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	histogram_checker #(.COUNT_BITS(COUNT_BITS), .OUT_W(OUT_W)) hist_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.fails    (fails),
		.checked  (checked),
		.pending  (pending),
		.peak_now (peak_now)
	);

	always #10 clk = ~clk;

	// stall the result channel in random bursts
	initial begin : result_sink
		int hold;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				hold = $urandom_range(1, 16);
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// hold one item on the input channel until it is taken, after an optional gap
	task automatic send_item(cmd_t op, logic [PIX_W-1:0] pix, logic [PIX_W-1:0] bin,
			logic [LEVEL_W-1:0] lvl);
		int gap;
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 16);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, lvl, bin, pix};
		do
			@(posedge clk);
		while (!s_tready);
		if (op == CMD_ADD)
			n_add++;
		else
			n_query++;
	endtask

	// mostly the busy bins, low entries favored, so peaks and ratios build up
	function automatic logic [PIX_W-1:0] pick_bin();
		if ($urandom_range(0, 99) < 55)
			return busy_bins[3'($urandom_range(0, 7) & $urandom_range(0, 7))];
		return PIX_W'($urandom_range(0, NUM_BINS - 1));
	endfunction

	task automatic random_items(int gaps, int stalls, int count);
		cmd_t               op;
		logic [LEVEL_W-1:0] lvl;
		gap_pct   = gaps;
		stall_pct = stalls;
		repeat (count) begin
			op  = ($urandom_range(0, 99) < 60) ? CMD_ADD : CMD_QUERY;
			lvl = LEVEL_W'($urandom_range(0, (1 << LEVEL_W) - 1));
			if ($urandom_range(0, 7) == 0)
				lvl = $urandom_range(0, 1) ? '1 : '0;
			send_item(op, pick_bin(), pick_bin(), lvl);
		end
	endtask

	initial begin : stimulus
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= CMD_ADD;
		for (int i = 0; i < 8; i++)
			busy_bins[i] = PIX_W'($urandom_range(0, NUM_BINS - 1));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store: only level 0 is reached
		gap_pct   = 30;
		stall_pct = 30;
		send_item(CMD_QUERY, 8'hFF, 8'h00, 6'd0);
		send_item(CMD_QUERY, 8'h00, 8'hFF, 6'd63);
		send_item(CMD_QUERY, 8'h00, 8'h80, 6'd1);

		// back-to-back adds on one bin, plus the top bin with noise in unused fields
		send_item(CMD_ADD, 8'h00, 8'hFF, 6'd63);
		send_item(CMD_ADD, 8'h00, 8'h00, 6'd0);
		send_item(CMD_ADD, 8'h00, 8'hAA, 6'd21);
		send_item(CMD_ADD, 8'hFF, 8'hFF, 6'd63);

		// bar boundaries against a peak of 3
		send_item(CMD_QUERY, 8'hFF, 8'h00, 6'd63);
		send_item(CMD_QUERY, 8'h00, 8'hFF, 6'd63);
		send_item(CMD_QUERY, 8'h00, 8'hFF, 6'd21);
		send_item(CMD_QUERY, 8'h00, 8'hFF, 6'd22);
		send_item(CMD_QUERY, 8'h00, 8'h11, 6'd0);
		send_item(CMD_QUERY, 8'h00, 8'h11, 6'd1);

		// query straight after an add on the same bin
		send_item(CMD_ADD, 8'hFF, 8'h00, 6'd0);
		send_item(CMD_QUERY, 8'h00, 8'hFF, 6'd42);
		send_item(CMD_QUERY, 8'h00, 8'hFF, 6'd43);

		// alternating bit patterns in every field
		send_item(CMD_ADD, 8'hAA, 8'h55, 6'h2A);
		send_item(CMD_ADD, 8'h55, 8'hAA, 6'h15);
		send_item(CMD_QUERY, 8'h55, 8'hAA, 6'h15);
		send_item(CMD_QUERY, 8'hAA, 8'h55, 6'h2A);
		send_item(CMD_QUERY, 8'h00, 8'h00, 6'd63);

		// random items: idling on both sides, none, heavy, and none at the end
		random_items(20, 20, 300);
		random_items(0, 0, 200);
		random_items(50, 50, 300);
		random_items(0, 0, 325);
		s_tvalid <= 1'b0;

		// drain the pipeline
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d pixel adds and %0d bar queries; %0d results compared.",
			n_add, n_query, checked);
		$display("Final peak %0d, with random gaps and stalls in some phases.", peak_now);
		if (fails == 0 && pending == 0) begin
			$display("testbench passed");
		end else begin
			if (pending != 0)
				$error("%0d expected results never arrived", pending);
			$display("testbench failed");
		end
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

endmodule
